// ===== rtl/clover_addback_accumulator_assert.svh =====
// Assertion macros shared by the clover add-back accumulator RTL.
// Depends on nothing; define NO_ASSERTIONS to compile them out.
`ifndef CLOVER_ADDBACK_ACCUMULATOR_ASSERT_SVH
`define CLOVER_ADDBACK_ACCUMULATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Property checked on every clock edge outside reset
`define CAB_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition in one cycle implies consequence in the next
`define CAB_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define CAB_ASSERT(lbl, clk, rstn, prop, msg)
`define CAB_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== rtl/cab_pkg.sv =====
// Package for the clover add-back accumulator: fixed port widths and
// the control bundle broadcast to the entry cells. No dependencies.
`default_nettype none

package cab_pkg;

  localparam int unsigned CloverW   = 4;
  localparam int unsigned EnergyInW = 16;
  localparam int unsigned SumOutW   = 24;

  // Control broadcast from the sequencer to every cell
  typedef struct packed {
    logic accept;  // a hit beat is taken this cycle
    logic found;   // some cell already holds the hit's clover
    logic shift;   // dump: every cell takes its upper neighbor's entry
  } cab_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/cab_cell.sv =====
// One entry cell of the add-back table: clover, saturating sum, valid.
// Depends on cab_pkg for the control bundle and clover width.
`default_nettype none

module cab_cell #(
  parameter int unsigned ENERGY_WIDTH = 16,
  parameter int unsigned SUM_WIDTH    = 24
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire cab_pkg::cab_ctrl_t             ctrl_i,
  input  wire logic [cab_pkg::CloverW-1:0]    hit_clover_i,
  input  wire logic [ENERGY_WIDTH-1:0]        hit_energy_i,
  input  wire logic                           prev_valid_i,
  input  wire logic                           nxt_valid_i,
  input  wire logic [cab_pkg::CloverW-1:0]    nxt_clover_i,
  input  wire logic [SUM_WIDTH-1:0]           nxt_sum_i,
  output logic                                valid_o,
  output logic [cab_pkg::CloverW-1:0]         clover_o,
  output logic [SUM_WIDTH-1:0]                sum_o,
  output logic                                match_o
);
  import cab_pkg::*;

  localparam int unsigned AddW = ((SUM_WIDTH > ENERGY_WIDTH) ? SUM_WIDTH : ENERGY_WIDTH) + 1;
  localparam logic [AddW-1:0] SumMax = AddW'({SUM_WIDTH{1'b1}});

  logic                 valid_q;
  logic [CloverW-1:0]   clover_q;
  logic [SUM_WIDTH-1:0] sum_q;
  logic                 append;
  logic [AddW-1:0]      base;
  logic [AddW-1:0]      total;
  logic [SUM_WIDTH-1:0] sum_d;

  // hit hits this cell, or this is the first free cell and nobody matched
  assign match_o = valid_q && (clover_q == hit_clover_i);
  assign append  = !valid_q && prev_valid_i && !ctrl_i.found;

  // saturating add; a fresh entry starts from zero
  always_comb begin
    base  = match_o ? AddW'(sum_q) : '0;
    total = base + AddW'(hit_energy_i);
    sum_d = (total > SumMax) ? {SUM_WIDTH{1'b1}} : total[SUM_WIDTH-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      valid_q <= nxt_valid_i;
    end else if (ctrl_i.accept && append) begin
      valid_q <= 1'b1;
    end
  end

  // payload: no reset
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      clover_q <= nxt_clover_i;
      sum_q    <= nxt_sum_i;
    end else if (ctrl_i.accept && (match_o || append)) begin
      clover_q <= hit_clover_i;
      sum_q    <= sum_d;
    end
  end

  assign valid_o  = valid_q;
  assign clover_o = clover_q;
  assign sum_o    = sum_q;

endmodule

`default_nettype wire

// ===== rtl/clover_addback_accumulator.sv =====
// Clover add-back accumulator: one hit beat per cycle while collecting an event;
// the end-of-event hit is merged in the cycle it is accepted. Emission starts the
// next cycle with N entry beats for N entries, one on each cycle the receiver does
// not stall, as the chain shifts toward cell 0; hit input stalls until the last is taken.
// Reset (rst_ni, async active low) empties the table and returns to collecting.
// Depends on cab_pkg, cab_cell and clover_addback_accumulator_assert.svh.
`default_nettype none
`include "clover_addback_accumulator_assert.svh"

module clover_addback_accumulator #(
  parameter int unsigned MAX_CLOVERS  = 16,
  parameter int unsigned ENERGY_WIDTH = 16,
  parameter int unsigned SUM_WIDTH    = 24
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [cab_pkg::CloverW-1:0]      clover_id_i,
  input  wire logic [cab_pkg::EnergyInW-1:0]    hit_energy_i,
  input  wire logic                             end_of_event_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [cab_pkg::CloverW-1:0]           out_clover_o,
  output logic [cab_pkg::SumOutW-1:0]           energy_sum_o,
  output logic                                  last_entry_o
);
  import cab_pkg::*;

  typedef enum logic {
    ST_COLLECT,
    ST_DUMP
  } cab_state_e;

  cab_state_e state_q;

  cab_ctrl_t                ctrl;
  logic [ENERGY_WIDTH-1:0]  energy;
  logic [MAX_CLOVERS-1:0]   valid_vec;
  logic [MAX_CLOVERS-1:0]   match_vec;
  logic [MAX_CLOVERS:0]     valid_hi;    // valid with an empty slot above the top cell
  logic [MAX_CLOVERS:0]     valid_lo;    // valid with an always-full slot below cell 0
  logic [CloverW-1:0]       clover_arr [MAX_CLOVERS+1];
  logic [SUM_WIDTH-1:0]     sum_arr    [MAX_CLOVERS+1];
  logic                     in_beat;
  logic                     out_beat;

  // energy is cut to its low ENERGY_WIDTH bits when ENERGY_WIDTH is narrower, else zero-extended
  if (ENERGY_WIDTH >= EnergyInW) begin : g_energy_ext
    assign energy = ENERGY_WIDTH'(hit_energy_i);
  end else begin : g_energy_cut
    assign energy = hit_energy_i[ENERGY_WIDTH-1:0];
  end

  assign in_stall_o = (state_q == ST_DUMP);
  assign in_beat    = in_valid_i && !in_stall_o;
  assign out_beat   = out_valid_o && !out_stall_i;

  assign ctrl.accept = in_beat;
  assign ctrl.found  = |match_vec;
  assign ctrl.shift  = out_beat;

  assign valid_hi = {1'b0, valid_vec};
  assign valid_lo = {valid_vec, 1'b1};
  assign clover_arr[MAX_CLOVERS] = '0;
  assign sum_arr[MAX_CLOVERS]    = '0;

  // chain of entry cells; cell i+1 feeds cell i while dumping
  for (genvar i = 0; i < MAX_CLOVERS; i++) begin : g_cell
    cab_cell #(
      .ENERGY_WIDTH (ENERGY_WIDTH),
      .SUM_WIDTH    (SUM_WIDTH)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .hit_clover_i (clover_id_i),
      .hit_energy_i (energy),
      .prev_valid_i (valid_lo[i]),
      .nxt_valid_i  (valid_hi[i+1]),
      .nxt_clover_i (clover_arr[i+1]),
      .nxt_sum_i    (sum_arr[i+1]),
      .valid_o      (valid_vec[i]),
      .clover_o     (clover_arr[i]),
      .sum_o        (sum_arr[i]),
      .match_o      (match_vec[i])
    );
  end

  // collect until the end-of-event beat, then dump until the last entry leaves
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_COLLECT;
    end else begin
      case (state_q)
        ST_COLLECT: if (in_beat && end_of_event_i) state_q <= ST_DUMP;
        ST_DUMP:    if (out_beat && last_entry_o) state_q <= ST_COLLECT;
        default:    state_q <= ST_COLLECT;
      endcase
    end
  end

  // results come straight from cell 0
  assign out_valid_o  = (state_q == ST_DUMP) && valid_vec[0];
  assign out_clover_o = clover_arr[0];
  assign last_entry_o = !valid_hi[1];

  if (SUM_WIDTH >= SumOutW) begin : g_sum_cut
    assign energy_sum_o = sum_arr[0][SumOutW-1:0];
  end else begin : g_sum_ext
    assign energy_sum_o = SumOutW'(sum_arr[0]);
  end

  // table stays packed from cell 0 upward
  `CAB_ASSERT(a_packed, clk_i, rst_ni, $onehot(valid_hi + 1'b1), "table entries not contiguous")
  // a clover is held by at most one cell
  `CAB_ASSERT(a_unique, clk_i, rst_ni, $onehot0(match_vec), "clover found in two cells")
  // dumping always has an entry at the head
  `CAB_ASSERT(a_dump_head, clk_i, rst_ni, (state_q != ST_DUMP) || valid_vec[0], "dump with empty head")
  // after the last entry leaves the table is empty and collecting resumes
  `CAB_ASSERT_NEXT(a_dump_end, clk_i, rst_ni, out_beat && last_entry_o, (valid_vec == '0) && (state_q == ST_COLLECT), "table not empty after dump")

endmodule

`default_nettype wire
